// ----- hw/rtl/pei_pkg.sv -----
// pei_pkg: shared types, codes, constants and helpers for the particle integrator
// used by pei_mul and particle_euler_integrator; no dependencies
package pei_pkg;

   // fixed field widths
   localparam int VEC_W      = 32;
   localparam int DT_W       = 16;
   localparam int DAMP_W     = 21;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int EXP_STEPS  = 16;
   localparam int EXP_ONE    = 30;
   localparam int SHIFT_W    = 6;
   localparam int MAX_SHIFT  = 33;
   localparam int FRAC_BITS_DEF = 16;

   // item modes
   localparam logic [2:0] MODE_ADD_FORCE = 3'd0;
   localparam logic [2:0] MODE_INTEGRATE = 3'd1;
   localparam logic [2:0] MODE_CLR_FORCE = 3'd2;
   localparam logic [2:0] MODE_CLR_VEL   = 3'd3;
   localparam logic [2:0] MODE_LOAD_POS  = 3'd4;
   localparam logic [2:0] MODE_LOAD_VEL  = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_INV_MASS = 3'd0;
   localparam logic [2:0] CSR_DAMP     = 3'd1;
   localparam logic [2:0] CSR_BASE_X   = 3'd2;
   localparam logic [2:0] CSR_BASE_Y   = 3'd3;
   localparam logic [2:0] CSR_BASE_Z   = 3'd4;
   localparam logic [2:0] CSR_GRAV_X   = 3'd5;
   localparam logic [2:0] CSR_GRAV_Y   = 3'd6;
   localparam logic [2:0] CSR_GRAV_Z   = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_GRAV, ST_POS_M, ST_POS_A, ST_ACC_M, ST_ACC_A, ST_VEL_M, ST_VEL_A,
      ST_EXP_M, ST_EXP_A, ST_FR_M, ST_FR_A, ST_DMP_M, ST_DMP_A, ST_OUT
   } state_type;

   typedef logic signed [VEC_W-1:0] vec_type [3];

   // 2^(2^-(k+1)) in Q2.30
   function automatic logic [31:0] root_val(input logic [3:0] k);
      logic [31:0] r;
      unique case (k)
         4'd0:  r = 32'd1518500250;
         4'd1:  r = 32'd1276901417;
         4'd2:  r = 32'd1170923762;
         4'd3:  r = 32'd1121280436;
         4'd4:  r = 32'd1097253708;
         4'd5:  r = 32'd1085434106;
         4'd6:  r = 32'd1079572136;
         4'd7:  r = 32'd1076653033;
         4'd8:  r = 32'd1075196443;
         4'd9:  r = 32'd1074468888;
         4'd10: r = 32'd1074105294;
         4'd11: r = 32'd1073923544;
         4'd12: r = 32'd1073832680;
         4'd13: r = 32'd1073787251;
         4'd14: r = 32'd1073764537;
         default: r = 32'd1073753181;
      endcase
      return r;
   endfunction

   // clip to signed 32 bits; top bit flags a clip
   function automatic logic [VEC_W:0] sat32(input logic signed [SUM_W-1:0] v);
      logic [VEC_W:0] r;
      if (v > SUM_W'(signed'(32'sh7fffffff))) r = {1'b1, 32'h7fffffff};
      else if (v < SUM_W'(signed'(32'sh80000000))) r = {1'b1, 32'h80000000};
      else r = {1'b0, v[VEC_W-1:0]};
      return r;
   endfunction

endpackage

// ----- hw/rtl/pei_mul.sv -----
// pei_mul: shared signed 33x33 multiplier with registered product
// depends on pei_pkg
module pei_mul (
   input  logic                              clock,
   input  logic signed [pei_pkg::MUL_W-1:0]  op_a,
   input  logic signed [pei_pkg::MUL_W-1:0]  op_b,
   output logic signed [pei_pkg::PROD_W-1:0] product
);
   import pei_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   // product register
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign product = prod_ff;

endmodule

// ----- hw/rtl/particle_euler_integrator.sv -----
// particle_euler_integrator: damped euler step for one particle, signed fixed point
// depends on pei_pkg and pei_mul
//
//   channel  | direction | handshake            | payload
//   req      | in        | req_valid/req_stall  | mode, vec_x/y/z, time_step
//   rsp      | out       | rsp_valid/rsp_stall  | pos_x/y/z, vel_x/y/z, saturated
//   csr      | in        | csr_we               | csr_index, csr_wdata
//
// integrate: gravity step, then 29 products for position, acceleration and velocity,
// exp2 and damping on the single shared multiplier, each with a multiply state and an
// add state
// other modes: result in the cycle after the transfer
// req_stall is high from transfer until the result transfer completes
// reset (synchronous) clears state vectors and loads register defaults
module particle_euler_integrator #(
   parameter int FRAC_BITS = pei_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_mode,
   input  logic signed [31:0]   req_vec_x,
   input  logic signed [31:0]   req_vec_y,
   input  logic signed [31:0]   req_vec_z,
   input  logic [15:0]          req_time_step,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_pos_x,
   output logic signed [31:0]   rsp_pos_y,
   output logic signed [31:0]   rsp_pos_z,
   output logic signed [31:0]   rsp_vel_x,
   output logic signed [31:0]   rsp_vel_y,
   output logic signed [31:0]   rsp_vel_z,
   output logic                 rsp_saturated,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import pei_pkg::*;

   localparam logic signed [PROD_W-1:0] HALF_DT = PROD_W'(1) <<< (DT_W - 1);
   localparam logic signed [PROD_W-1:0] HALF_FR = PROD_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] HALF_EX = PROD_W'(1) <<< (EXP_ONE - 1);

   state_type state_ff, state_in;
   logic [1:0] c_ff;
   logic [3:0] k_ff;

   // configuration registers
   logic [31:0]               inv_mass_ff;
   logic signed [DAMP_W-1:0]  damp_ff;
   vec_type                   base_ff, grav_ff;

   // particle state and scratch
   vec_type                   pos_ff, vel_ff, frc_ff;
   logic signed [VEC_W-1:0]   acc_ff;
   logic [31:0]               fac_ff;
   logic [DT_W-1:0]           dt_ff, fr_ff;
   logic [SHIFT_W-1:0]        n_ff;
   logic                      sat_ff;

   logic                      req_xfer;
   vec_type                   req_vec;
   logic signed [MUL_W-1:0]   op_a, op_b;
   logic signed [PROD_W-1:0]  product;
   logic signed [PROD_W-1:0]  rnd_dt, rnd_fr, rnd_dmp, e_val, ip_neg;
   logic [PROD_W-1:0]         rnd_ex;
   logic [6:0]                dmp_sh;

   assign req_vec[0] = req_vec_x;
   assign req_vec[1] = req_vec_y;
   assign req_vec[2] = req_vec_z;
   assign req_xfer   = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_xfer) state_in = (req_mode == MODE_INTEGRATE) ? ST_GRAV : ST_OUT;
         ST_GRAV:  state_in = ST_POS_M;
         ST_POS_M: state_in = ST_POS_A;
         ST_POS_A: state_in = (c_ff == 2'd2) ? ST_ACC_M : ST_POS_M;
         ST_ACC_M: state_in = ST_ACC_A;
         ST_ACC_A: state_in = ST_VEL_M;
         ST_VEL_M: state_in = ST_VEL_A;
         ST_VEL_A: state_in = (c_ff == 2'd2) ? ST_EXP_M : ST_ACC_M;
         ST_EXP_M: state_in = ST_EXP_A;
         ST_EXP_A: state_in = ST_FR_M;
         ST_FR_M:  state_in = ST_FR_A;
         ST_FR_A:  state_in = (k_ff == 4'(EXP_STEPS - 1)) ? ST_DMP_M : ST_FR_M;
         ST_DMP_M: state_in = ST_DMP_A;
         ST_DMP_A: state_in = (c_ff == 2'd2) ? ST_OUT : ST_DMP_M;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      rsp_valid = (state_ff == ST_OUT);
      req_stall = (state_ff != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // shared multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_POS_M: begin op_a = MUL_W'(vel_ff[c_ff]); op_b = MUL_W'(signed'({1'b0, dt_ff})); end
         ST_ACC_M: begin op_a = MUL_W'(frc_ff[c_ff]); op_b = signed'({1'b0, inv_mass_ff}); end
         ST_VEL_M: begin op_a = MUL_W'(acc_ff);       op_b = MUL_W'(signed'({1'b0, dt_ff})); end
         ST_EXP_M: begin op_a = MUL_W'(signed'({1'b0, dt_ff})); op_b = MUL_W'(damp_ff); end
         ST_FR_M:  begin op_a = signed'({1'b0, fac_ff}); op_b = signed'({1'b0, root_val(k_ff)}); end
         ST_DMP_M: begin op_a = MUL_W'(vel_ff[c_ff]); op_b = signed'({1'b0, fac_ff}); end
         default: ;
      endcase
   end

   pei_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // rounding of the registered product
   always_comb begin
      dmp_sh  = 7'(EXP_ONE) + {1'b0, n_ff};
      rnd_dt  = (product + HALF_DT) >>> DT_W;
      rnd_fr  = (product + HALF_FR) >>> FRAC_BITS;
      rnd_ex  = unsigned'((product + HALF_EX) >>> EXP_ONE);
      rnd_dmp = (product + ((PROD_W'(1)) <<< (dmp_sh - 7'd1))) >>> dmp_sh;
      e_val   = (rnd_dt > 0) ? '0 : rnd_dt;
      ip_neg  = -(e_val >>> EXP_STEPS);
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= '0;
         k_ff <= '0;
      end else begin
         if (state_ff == ST_POS_A || state_ff == ST_VEL_A || state_ff == ST_DMP_A)
            c_ff <= (c_ff == 2'd2) ? 2'd0 : c_ff + 2'd1;
         if (state_ff == ST_FR_A) k_ff <= k_ff + 4'd1;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mass_ff <= 32'd65536;
         damp_ff     <= '0;
         base_ff     <= '{default: '0};
         grav_ff     <= '{32'sd0, -32'sd642253, 32'sd0};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INV_MASS: inv_mass_ff <= csr_wdata;
            CSR_DAMP:     damp_ff     <= signed'(csr_wdata[DAMP_W-1:0]);
            CSR_BASE_X:   base_ff[0]  <= signed'(csr_wdata);
            CSR_BASE_Y:   base_ff[1]  <= signed'(csr_wdata);
            CSR_BASE_Z:   base_ff[2]  <= signed'(csr_wdata);
            CSR_GRAV_X:   grav_ff[0]  <= signed'(csr_wdata);
            CSR_GRAV_Y:   grav_ff[1]  <= signed'(csr_wdata);
            CSR_GRAV_Z:   grav_ff[2]  <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   // particle state
   always_ff @(posedge clock) begin
      logic [VEC_W:0] s0, s1, s2;
      if (reset) begin
         pos_ff <= '{default: '0};
         vel_ff <= '{default: '0};
         frc_ff <= '{default: '0};
         sat_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (req_xfer) begin
               dt_ff  <= req_time_step;
               sat_ff <= 1'b0;
               unique case (req_mode)
                  MODE_ADD_FORCE: begin
                     s0 = sat32(SUM_W'(frc_ff[0]) + SUM_W'(req_vec[0]));
                     s1 = sat32(SUM_W'(frc_ff[1]) + SUM_W'(req_vec[1]));
                     s2 = sat32(SUM_W'(frc_ff[2]) + SUM_W'(req_vec[2]));
                     frc_ff <= '{s0[31:0], s1[31:0], s2[31:0]};
                     sat_ff <= s0[32] | s1[32] | s2[32];
                  end
                  MODE_CLR_FORCE: frc_ff <= '{default: '0};
                  MODE_CLR_VEL:   vel_ff <= '{default: '0};
                  MODE_LOAD_POS:  pos_ff <= req_vec;
                  MODE_LOAD_VEL:  vel_ff <= req_vec;
                  default: ;
               endcase
            end
            ST_GRAV: begin
               s0 = sat32(SUM_W'(frc_ff[0]) + SUM_W'(grav_ff[0]));
               s1 = sat32(SUM_W'(frc_ff[1]) + SUM_W'(grav_ff[1]));
               s2 = sat32(SUM_W'(frc_ff[2]) + SUM_W'(grav_ff[2]));
               frc_ff <= '{s0[31:0], s1[31:0], s2[31:0]};
               sat_ff <= sat_ff | s0[32] | s1[32] | s2[32];
            end
            ST_POS_A: begin
               s0 = sat32(SUM_W'(pos_ff[c_ff]) + SUM_W'(rnd_dt));
               pos_ff[c_ff] <= s0[31:0];
               sat_ff <= sat_ff | s0[32];
            end
            ST_ACC_A: begin
               s0 = sat32(SUM_W'(base_ff[c_ff]) + SUM_W'(rnd_fr));
               acc_ff <= s0[31:0];
               sat_ff <= sat_ff | s0[32];
            end
            ST_VEL_A: begin
               s0 = sat32(SUM_W'(vel_ff[c_ff]) + SUM_W'(rnd_dt));
               vel_ff[c_ff] <= s0[31:0];
               sat_ff <= sat_ff | s0[32];
            end
            ST_EXP_A: begin
               fr_ff  <= e_val[DT_W-1:0];
               n_ff   <= (ip_neg > PROD_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT)
                                                       : ip_neg[SHIFT_W-1:0];
               fac_ff <= 32'd1 << EXP_ONE;
            end
            ST_FR_A: if (fr_ff[4'(EXP_STEPS - 1) - k_ff]) fac_ff <= rnd_ex[31:0];
            ST_DMP_A: begin
               s0 = sat32(SUM_W'(rnd_dmp));
               vel_ff[c_ff] <= s0[31:0];
               sat_ff <= sat_ff | s0[32];
            end
            default: ;
         endcase
      end
   end

   assign rsp_pos_x     = pos_ff[0];
   assign rsp_pos_y     = pos_ff[1];
   assign rsp_pos_z     = pos_ff[2];
   assign rsp_vel_x     = vel_ff[0];
   assign rsp_vel_y     = vel_ff[1];
   assign rsp_vel_z     = vel_ff[2];
   assign rsp_saturated = sat_ff;

   // a result never shows while a new item could be taken
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("result shown while input open");

   // clear force empties the whole sum
   a_clr_force: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_mode == MODE_CLR_FORCE |=>
         frc_ff[0] == 0 && frc_ff[1] == 0 && frc_ff[2] == 0 && rsp_valid && !rsp_saturated)
      else $error("force sum not cleared");

   // a non-integrate item reports in the next cycle
   a_short_item: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_mode != MODE_INTEGRATE |=> rsp_valid)
      else $error("short item late");

   // exp2 pass only starts from unity
   a_exp_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXP_A |=> fac_ff == (32'd1 << EXP_ONE) && k_ff == 4'd0)
      else $error("exp2 start wrong");

endmodule

// ----- verif/tb_particle_euler_integrator.sv -----
// tb_particle_euler_integrator: self-checking bench for the damped particle integrator
// depends on pei_pkg and the particle_euler_integrator rtl
module tb_particle_euler_integrator;
   timeunit 1ns;
   timeprecision 1ps;
   import pei_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int N_RANDOM     = 380;

   // spare mode codes with no operation
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_mode;
   logic signed [31:0] req_vec_x, req_vec_y, req_vec_z;
   logic [15:0]        req_time_step;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic               rsp_saturated;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   particle_euler_integrator dut (.*);

   typedef struct {
      logic signed [31:0] pos [3];
      logic signed [31:0] vel [3];
      logic               sat;
   } state_rpt_type;

   typedef struct {
      logic [2:0]         mode;
      logic signed [31:0] vec [3];
      logic [15:0]        dt;
      logic               check_typed;
      state_rpt_type      typed;
   } motion_cmd_type;

   // own copy of registers and particle state
   logic [31:0]        m_inv_mass;
   logic signed [31:0] m_damp;
   logic signed [31:0] m_base [3];
   logic signed [31:0] m_grav [3];
   logic signed [31:0] m_pos [3];
   logic signed [31:0] m_vel [3];
   logic signed [31:0] m_force [3];

   state_rpt_type  expected_states [$];
   motion_cmd_type cmd_queue [$];
   int             errors;
   int             cycles;
   bit             rx_hold;
   bit             quiet;

   // 2^(2^-(k+1)) in Q2.30
   localparam logic [31:0] ROOTS [16] = '{
      32'd1518500250, 32'd1276901417, 32'd1170923762, 32'd1121280436,
      32'd1097253708, 32'd1085434106, 32'd1079572136, 32'd1076653033,
      32'd1075196443, 32'd1074468888, 32'd1074105294, 32'd1073923544,
      32'd1073832680, 32'd1073787251, 32'd1073764537, 32'd1073753181};

   function automatic longint flr_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint rnd_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   // clip to 32 bits, flagging a clip
   function automatic logic signed [31:0] clip32(longint v, ref logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // 128-bit rounding shift for the damping product
   function automatic longint rnd_shift_wide(longint v, longint f, int s);
      logic signed [127:0] p;
      p = $signed(128'(v)) * $signed(128'(f));
      p = (p + (128'sd1 <<< (s - 1))) >>> s;
      if (p > 128'sd4611686018427387903) return 64'sh3fffffffffffffff;
      if (p < -128'sd4611686018427387904) return -64'sh4000000000000000;
      return longint'(p);
   endfunction

   task automatic reset_model();
      m_inv_mass = 32'd65536;
      m_damp = 0;
      for (int c = 0; c < 3; c++) begin
         m_base[c] = 0; m_grav[c] = 0; m_pos[c] = 0; m_vel[c] = 0; m_force[c] = 0;
      end
      m_grav[1] = -32'sd642253;
   endtask

   // predicted particle state after one transfer
   function automatic state_rpt_type advance_particle(motion_cmd_type it);
      state_rpt_type r;
      logic       sat;
      longint     dt, e, ip, n, acc_v;
      logic [15:0] fr;
      logic [63:0] factor;
      logic [127:0] wp;
      sat = 1'b0;
      dt = longint'(it.dt);
      case (it.mode)
         MODE_ADD_FORCE:
            for (int c = 0; c < 3; c++)
               m_force[c] = clip32(longint'(m_force[c]) + longint'(it.vec[c]), sat);
         MODE_INTEGRATE: begin
            for (int c = 0; c < 3; c++)
               m_force[c] = clip32(longint'(m_force[c]) + longint'(m_grav[c]), sat);
            for (int c = 0; c < 3; c++)
               m_pos[c] = clip32(longint'(m_pos[c]) + rnd_shift(longint'(m_vel[c]) * dt, 16),
                                 sat);
            for (int c = 0; c < 3; c++) begin
               acc_v = clip32(longint'(m_base[c]) +
                       rnd_shift(longint'(m_force[c]) * longint'({32'd0, m_inv_mass}), 16), sat);
               m_vel[c] = clip32(longint'(m_vel[c]) + rnd_shift(acc_v * dt, 16), sat);
            end
            e = rnd_shift(dt * longint'(m_damp), 16);
            if (e > 0) e = 0;
            ip = flr_shift(e, 16);
            fr = e[15:0];
            n = -ip;
            if (n > MAX_SHIFT) n = MAX_SHIFT;
            factor = 64'd1 << 30;
            for (int k = 0; k < 16; k++)
               if (fr[15-k]) begin
                  wp = 128'(factor) * 128'(ROOTS[k]) + (128'd1 << 29);
                  factor = 64'(wp >> 30);
               end
            for (int c = 0; c < 3; c++)
               m_vel[c] = clip32(rnd_shift_wide(longint'(m_vel[c]), longint'(factor),
                                                30 + int'(n)), sat);
         end
         MODE_CLR_FORCE: for (int c = 0; c < 3; c++) m_force[c] = 0;
         MODE_CLR_VEL:   for (int c = 0; c < 3; c++) m_vel[c] = 0;
         MODE_LOAD_POS:  for (int c = 0; c < 3; c++) m_pos[c] = it.vec[c];
         MODE_LOAD_VEL:  for (int c = 0; c < 3; c++) m_vel[c] = it.vec[c];
         default: ;
      endcase
      r.pos = m_pos;
      r.vel = m_vel;
      r.sat = sat;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   // clock and cycle limit
   initial begin
      clock = 1'b0;
      forever begin
         #2 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("particle_euler_integrator test failed");
         $finish;
      end
   end

   // result checking
   always @(posedge clock) begin
      state_rpt_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_states.size() == 0) begin
            report_mismatch("unexpected result transfer", 1, 0);
         end else begin
            w = expected_states.pop_front();
            if (rsp_pos_x !== w.pos[0]) report_mismatch("pos_x", rsp_pos_x, w.pos[0]);
            if (rsp_pos_y !== w.pos[1]) report_mismatch("pos_y", rsp_pos_y, w.pos[1]);
            if (rsp_pos_z !== w.pos[2]) report_mismatch("pos_z", rsp_pos_z, w.pos[2]);
            if (rsp_vel_x !== w.vel[0]) report_mismatch("vel_x", rsp_vel_x, w.vel[0]);
            if (rsp_vel_y !== w.vel[1]) report_mismatch("vel_y", rsp_vel_y, w.vel[1]);
            if (rsp_vel_z !== w.vel[2]) report_mismatch("vel_z", rsp_vel_z, w.vel[2]);
            if (rsp_saturated !== w.sat) report_mismatch("saturated", rsp_saturated, w.sat);
         end
      end
   end

   // receiver stall: long hold-off on request, else random bursts unless quiet
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold) begin
            rsp_stall <= 1'b1;
            for (int i = 0; i < 300; i++) @(negedge clock);
            rsp_stall <= 1'b0;
            rx_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 14);
            rsp_stall <= 1'b1;
            for (int i = 0; i < n; i++) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_INV_MASS: m_inv_mass = val;
         CSR_DAMP:     m_damp = {{11{val[20]}}, val[20:0]};
         CSR_BASE_X, CSR_BASE_Y, CSR_BASE_Z: m_base[idx - CSR_BASE_X] = val;
         default:      m_grav[idx - CSR_GRAV_X] = val;
      endcase
   endtask

   // one request transfer, predicting at acceptance
   task automatic send_cmd(motion_cmd_type it);
      state_rpt_type p;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_vec_x <= it.vec[0];
      req_vec_y <= it.vec[1];
      req_vec_z <= it.vec[2];
      req_time_step <= it.dt;
      do @(posedge clock); while (req_stall);
      p = advance_particle(it);
      if (it.check_typed) begin
         for (int c = 0; c < 3; c++) begin
            if (p.pos[c] !== it.typed.pos[c])
               report_mismatch("typed position", p.pos[c], it.typed.pos[c]);
            if (p.vel[c] !== it.typed.vel[c])
               report_mismatch("typed velocity", p.vel[c], it.typed.vel[c]);
         end
         if (p.sat !== it.typed.sat) report_mismatch("typed saturated", p.sat, it.typed.sat);
      end
      expected_states.push_back(p);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_states.size() != 0) @(negedge clock);
      repeat (70) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rnd_val();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         3: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
         default: return $urandom;
      endcase
   endfunction

   function automatic motion_cmd_type mk(logic [2:0] m, logic signed [31:0] x,
                                         logic signed [31:0] y, logic signed [31:0] z,
                                         logic [15:0] dt);
      motion_cmd_type it;
      it.mode = m; it.vec[0] = x; it.vec[1] = y; it.vec[2] = z; it.dt = dt;
      it.check_typed = 1'b0;
      return it;
   endfunction

   function automatic motion_cmd_type mk_typed(motion_cmd_type it, logic signed [31:0] p0,
      logic signed [31:0] p1, logic signed [31:0] p2, logic signed [31:0] v0,
      logic signed [31:0] v1, logic signed [31:0] v2, logic s);
      it.check_typed = 1'b1;
      it.typed.pos = '{p0, p1, p2};
      it.typed.vel = '{v0, v1, v2};
      it.typed.sat = s;
      return it;
   endfunction

   // stimulus
   initial begin
      logic [2:0]  m;
      int          r;
      errors = 0; cycles = 0; rx_hold = 0; quiet = 0;
      reset = 1'b1;
      req_valid = 0; req_mode = MODE_ADD_FORCE;
      req_vec_x = 0; req_vec_y = 0; req_vec_z = 0; req_time_step = 0;
      csr_we = 0; csr_index = CSR_INV_MASS; csr_wdata = 0;
      reset_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      cmd_queue.push_back(mk_typed(mk(MODE_SPARE_A, 5, 5, 5, 16'hffff), 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_typed(mk(MODE_SPARE_B, -1, -1, -1, 0), 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(mk_typed(mk(MODE_LOAD_POS, 32'sh7fffffff, 32'sh80000000, -1, 0),
                                   32'sh7fffffff, 32'sh80000000, -1, 0, 0, 0, 0));
      cmd_queue.push_back(mk_typed(mk(MODE_LOAD_VEL, 32'sh80000000, 32'sh7fffffff, 1, 0),
                                   32'sh7fffffff, 32'sh80000000, -1,
                                   32'sh80000000, 32'sh7fffffff, 1, 0));
      cmd_queue.push_back(mk(MODE_INTEGRATE, 0, 0, 0, 16'hffff));
      cmd_queue.push_back(mk(MODE_ADD_FORCE, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0));
      cmd_queue.push_back(mk(MODE_ADD_FORCE, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0));
      cmd_queue.push_back(mk(MODE_INTEGRATE, 0, 0, 0, 16'h8000));
      cmd_queue.push_back(mk(MODE_CLR_FORCE, 1, 2, 3, 0));
      cmd_queue.push_back(mk(MODE_LOAD_POS, 0, 0, 0, 0));
      cmd_queue.push_back(mk(MODE_LOAD_VEL, 32'sh00010000, -32'sh00020000, 32'sh00008000, 0));
      cmd_queue.push_back(mk(MODE_INTEGRATE, 0, 0, 0, 16'h0001));
      cmd_queue.push_back(mk(MODE_INTEGRATE, 0, 0, 0, 16'h0000));
      cmd_queue.push_back(mk(MODE_CLR_VEL, 0, 0, 0, 0));
      foreach (cmd_queue[i]) send_cmd(cmd_queue[i]);
      drain();

      // strong damping, immovable mass, base acceleration
      write_reg(CSR_DAMP, 32'h100000);
      write_reg(CSR_INV_MASS, 32'd0);
      write_reg(CSR_BASE_X, 32'h7fffffff);
      write_reg(CSR_BASE_Y, 32'h80000000);
      write_reg(CSR_BASE_Z, 32'h00030000);
      send_cmd(mk(MODE_LOAD_VEL, 32'sh40000000, -32'sh40000000, 32'sh00100000, 0));
      send_cmd(mk(MODE_INTEGRATE, 0, 0, 0, 16'hffff));
      send_cmd(mk(MODE_LOAD_VEL, 32'sh40000000, -32'sh40000000, 32'sh00100000, 0));
      send_cmd(mk(MODE_INTEGRATE, 0, 0, 0, 16'h0100));
      // a second step under the same strong damping
      send_cmd(mk(MODE_INTEGRATE, 0, 0, 0, 16'h0200));
      drain();
      write_reg(CSR_DAMP, 32'h0fffff);
      write_reg(CSR_INV_MASS, 32'hffffffff);
      write_reg(CSR_GRAV_X, 32'h7fffffff);
      write_reg(CSR_GRAV_Y, 32'h80000000);
      write_reg(CSR_GRAV_Z, 32'hfff00000);
      send_cmd(mk(MODE_INTEGRATE, 0, 0, 0, 16'h4000));
      send_cmd(mk(MODE_INTEGRATE, 0, 0, 0, 16'hffff));
      drain();

      // random phases with different settings
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_INV_MASS, ph == 0 ? 32'd65536 : $urandom_range(0, 1 << 20));
         write_reg(CSR_DAMP, ph == 3 ? 32'h000000 : (32'h100000 | $urandom_range(0, 20'hfffff)));
         for (int c = 0; c < 3; c++) begin
            write_reg(3'(CSR_BASE_X + c), $signed($urandom_range(0, 1 << 22)) - (1 << 21));
            write_reg(3'(CSR_GRAV_X + c), ph == 2 ? rnd_val() :
                      $signed($urandom_range(0, 1 << 22)) - (1 << 21));
         end
         if (ph == 1) rx_hold = 1'b1;
         if (ph == 3) quiet = 1'b1;
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            r = $urandom_range(0, 9);
            m = (r > 7) ? MODE_INTEGRATE : 3'(r);
            send_cmd(mk(m, rnd_val(), rnd_val(), rnd_val(), 16'($urandom)));
         end
         drain();
      end

      if (errors == 0) begin
         $display("particle_euler_integrator test passed");
      end else begin
         $display("particle_euler_integrator test failed");
      end
      $finish;
   end
endmodule

// ----- particle_euler_integrator.f -----
hw/rtl/pei_pkg.sv
hw/rtl/pei_mul.sv
hw/rtl/particle_euler_integrator.sv
verif/tb_particle_euler_integrator.sv
